// File: rtl/cp1600_cpu_core_macros.svh
// Assertion helpers used by the core's top-level RTL file.
`ifndef CP1600_CPU_CORE_MACROS_SVH
`define CP1600_CPU_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CP16_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CP16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cp16_pkg.sv
`timescale 1ns / 1ps
package cp16_pkg;

  localparam logic [15:0] ResetAddrDefault = 16'h1000;
  localparam logic [15:0] IrqVectorDefault = 16'h1004;

  // Flag bit positions in the status nibble.
  localparam int unsigned FlS = 3;
  localparam int unsigned FlZ = 2;
  localparam int unsigned FlO = 1;
  localparam int unsigned FlC = 0;

  typedef enum logic [3:0] {
    ST_FETCH = 4'd0,
    ST_ADDR  = 4'd1,
    ST_OPLO  = 4'd2,
    ST_OPHI  = 4'd3,
    ST_WRITE = 4'd4,
    ST_BDISP = 4'd5,
    ST_JMP1  = 4'd6,
    ST_JMP2  = 4'd7,
    ST_IRQW  = 4'd8
  } step_e;

  typedef struct packed {
    logic [7:0][15:0] rf;
    logic [3:0]       flags;
    logic             dbl;
    logic             ie;
    logic             intr;
    step_e            step;
    logic [9:0]       opc;
    logic [15:0]      oplat;
    logic [15:0]      addr;
  } cpu_state_t;

  typedef struct packed {
    logic        err;
    logic        granted;
    logic [4:0]  cycles;
    logic        done;
    logic [15:0] wdata;
    logic        wr;
    logic [15:0] addr;
  } bus_res_t;

  typedef struct packed {
    logic [15:0] r;
    logic [3:0]  f;
  } alu_res_t;

  function automatic logic [3:0] set_sz(input logic [3:0] f, input logic [15:0] v);
    logic [3:0] o;
    o = f;
    o[FlS] = v[15];
    o[FlZ] = (v == 16'h0000);
    return o;
  endfunction

  function automatic logic [3:0] set_sz_low(input logic [3:0] f, input logic [15:0] v);
    logic [3:0] o;
    o = f;
    o[FlS] = v[7];
    o[FlZ] = (v == 16'h0000);
    return o;
  endfunction

  function automatic alu_res_t alu_add(input logic [15:0] a, input logic [15:0] b,
                                       input logic cin, input logic [3:0] f);
    alu_res_t   o;
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b} + {16'h0000, cin};
    o.r = s[15:0];
    o.f = f;
    o.f[FlC] = s[16];
    o.f[FlO] = ~(a[15] ^ b[15]) & (a[15] ^ s[15]);
    o.f = set_sz(o.f, o.r);
    return o;
  endfunction

  function automatic alu_res_t shift_op(input logic [2:0] op, input logic dbl,
                                        input logic [15:0] r, input logic [3:0] f);
    alu_res_t o;
    logic     c;
    logic     ov;
    logic     sg;
    logic [15:0] v;
    o.f = f;
    c   = f[FlC];
    ov  = f[FlO];
    sg  = r[15];
    v   = r;
    case (op)
      3'd0: begin
        v = dbl ? {r[7:0], r[7:0]} : {r[7:0], r[15:8]};
        o.f = set_sz_low(o.f, v);
      end
      3'd1: begin
        v = dbl ? {r[13:0], 2'b00} : {r[14:0], 1'b0};
        o.f = set_sz(o.f, v);
      end
      3'd2, 3'd3: begin
        o.f[FlC] = sg;
        if (dbl) begin
          o.f[FlO] = r[14];
          v = {r[13:0], 2'b00};
          if (op == 3'd2) v[1:0] = {c, ov};
        end else begin
          v = {r[14:0], 1'b0};
          if (op == 3'd2) v[0] = c;
        end
        o.f = set_sz(o.f, v);
      end
      3'd4: begin
        v = dbl ? {2'b00, r[15:2]} : {1'b0, r[15:1]};
        o.f = set_sz_low(o.f, v);
      end
      3'd6: begin
        o.f[FlC] = r[0];
        if (dbl) begin
          o.f[FlO] = r[1];
          v = {ov, c, r[15:2]};
        end else begin
          v = {c, r[15:1]};
        end
        o.f = set_sz_low(o.f, v);
      end
      default: begin
        if (op == 3'd7) begin
          o.f[FlC] = r[0];
          if (dbl) o.f[FlO] = r[1];
        end
        v = dbl ? {sg, sg, r[15:2]} : {sg, r[15:1]};
        o.f = set_sz_low(o.f, v);
      end
    endcase
    o.r = v;
    return o;
  endfunction

  function automatic logic branch_taken(input logic [3:0] cond, input logic [3:0] f);
    logic t;
    case (cond[2:0])
      3'd0: t = 1'b1;
      3'd1: t = f[FlC];
      3'd2: t = f[FlO];
      3'd3: t = ~f[FlS];
      3'd4: t = f[FlZ];
      3'd5: t = f[FlS] ^ f[FlO];
      3'd6: t = f[FlZ] | (f[FlS] ^ f[FlO]);
      default: t = f[FlC] ^ f[FlS];
    endcase
    return cond[3] ? ~t : t;
  endfunction

endpackage

// File: rtl/cp16_exec.sv
`timescale 1ns / 1ps
module cp16_exec (
  input  cp16_pkg::cpu_state_t st_i,
  input  logic [15:0]          rd_i,
  input  logic                 irq_i,
  input  logic                 breq_i,
  input  logic [15:0]          ivec_i,
  output cp16_pkg::cpu_state_t ns_o,
  output cp16_pkg::bus_res_t   res_o
);
  import cp16_pkg::*;

  cpu_state_t  ns;
  bus_res_t    res;
  logic [9:0]  opc;
  logic [2:0]  mode;
  logic [2:0]  d;
  logic [2:0]  s;
  logic        fin;
  logic [4:0]  fcyc;
  logic        mem;
  logic [15:0] mval;
  logic [4:0]  mcyc;
  logic [15:0] ta;
  logic [15:0] disp;
  alu_res_t    ar;

  always_comb begin
    ns   = st_i;
    res  = '0;
    fin  = 1'b0;
    fcyc = '0;
    mem  = 1'b0;
    mval = '0;
    mcyc = '0;
    ta   = '0;
    disp = '0;
    ar   = '0;
    opc  = st_i.opc;
    mode = opc[5:3];
    d    = opc[2:0];
    s    = opc[5:3];
    res.addr = st_i.rf[7];
    unique case (st_i.step)
      ST_FETCH: begin
        if (st_i.intr && breq_i) begin
          // Bus yielded: the opcode word is dropped and fetched again.
          res.granted = 1'b1;
          res.done    = 1'b1;
          res.cycles  = 5'd1;
          ns.step     = ST_FETCH;
          res.addr    = st_i.rf[7];
        end else begin
          ns.rf[7] = st_i.rf[7] + 16'd1;
          ns.intr  = 1'b1;
          ns.opc   = rd_i[9:0];
          opc      = rd_i[9:0];
          mode     = opc[5:3];
          d        = opc[2:0];
          s        = opc[5:3];
          if (opc == 10'd1) begin
            ns.dbl     = 1'b1;
            res.done   = 1'b1;
            res.cycles = 5'd4;
            ns.step    = ST_FETCH;
            res.addr   = ns.rf[7];
          end else if (opc[9]) begin
            if (opc[8:6] == 3'd0) begin
              ns.step  = ST_BDISP;
              res.addr = ns.rf[7];
              ns.rf[7] = ns.rf[7] + 16'd1;
            end else if (mode == 3'd0) begin
              ns.step  = ST_ADDR;
              res.addr = ns.rf[7];
              ns.rf[7] = ns.rf[7] + 16'd1;
            end else if (opc[8:6] == 3'd1) begin
              // MVO through a pointer register.
              res.addr = ns.rf[mode];
              if (mode[2]) ns.rf[mode] = ns.rf[mode] + 16'd1;
              res.wr    = 1'b1;
              res.wdata = ns.rf[d];
              ns.step   = ST_WRITE;
            end else begin
              ns.step = ST_OPLO;
              if (mode == 3'd6) begin
                ns.rf[6] = ns.rf[6] - 16'd1;
                res.addr = ns.rf[6];
              end else begin
                res.addr = ns.rf[mode];
                if (mode[2]) ns.rf[mode] = ns.rf[mode] + 16'd1;
              end
            end
          end else begin
            fin  = 1'b1;
            fcyc = 5'd6;
            case (opc[8:6])
              3'd0: begin
                case (s)
                  3'd0: begin
                    fcyc = 5'd4;
                    case (d)
                      3'd2: begin ns.ie = 1'b1; ns.intr = 1'b0; end
                      3'd3: begin ns.ie = 1'b0; ns.intr = 1'b0; end
                      3'd4: begin
                        fin      = 1'b0;
                        ns.step  = ST_JMP1;
                        res.addr = ns.rf[7];
                        ns.rf[7] = ns.rf[7] + 16'd1;
                      end
                      3'd5: ns.intr = 1'b0;
                      3'd6: begin ns.flags[FlC] = 1'b0; ns.intr = 1'b0; end
                      3'd7: begin ns.flags[FlC] = 1'b1; ns.intr = 1'b0; end
                      default: ;
                    endcase
                  end
                  3'd1: begin
                    ns.rf[d] = ns.rf[d] + 16'd1;
                    ns.flags = set_sz(ns.flags, ns.rf[d]);
                  end
                  3'd2: begin
                    ns.rf[d] = ns.rf[d] - 16'd1;
                    ns.flags = set_sz(ns.flags, ns.rf[d]);
                  end
                  3'd3: begin
                    ns.rf[d] = ~ns.rf[d];
                    ns.flags = set_sz(ns.flags, ns.rf[d]);
                  end
                  3'd4: begin
                    ar = alu_add(16'h0000, ~ns.rf[d], 1'b1, ns.flags);
                    ns.rf[d] = ar.r;
                    ns.flags = ar.f;
                  end
                  3'd5: begin
                    ar = alu_add(ns.rf[d], 16'h0000, ns.flags[FlC], ns.flags);
                    ns.rf[d] = ar.r;
                    ns.flags = ar.f;
                  end
                  3'd6: begin
                    if (!d[2]) ns.rf[d] = {ns.flags, 4'h0, ns.flags, 4'h0};
                  end
                  default: ns.flags = ns.rf[d][7:4];
                endcase
              end
              3'd1: begin
                ns.intr = 1'b0;
                fcyc    = opc[2] ? 5'd8 : 5'd6;
                ar = shift_op(s, opc[2], ns.rf[{1'b0, opc[1:0]}], ns.flags);
                ns.rf[{1'b0, opc[1:0]}] = ar.r;
                ns.flags = ar.f;
              end
              3'd2: begin
                ns.rf[d] = ns.rf[s];
                ns.flags = set_sz(ns.flags, ns.rf[d]);
                if (d[2] && d[1]) fcyc = 5'd7;
              end
              3'd3: begin
                ar = alu_add(ns.rf[d], ns.rf[s], 1'b0, ns.flags);
                ns.rf[d] = ar.r;
                ns.flags = ar.f;
              end
              3'd4: begin
                ar = alu_add(ns.rf[d], ~ns.rf[s], 1'b1, ns.flags);
                ns.rf[d] = ar.r;
                ns.flags = ar.f;
              end
              3'd5: begin
                ar = alu_add(ns.rf[d], ~ns.rf[s], 1'b1, ns.flags);
                ns.flags = ar.f;
              end
              3'd6: begin
                ns.rf[d] = ns.rf[d] & ns.rf[s];
                ns.flags = set_sz(ns.flags, ns.rf[d]);
              end
              default: begin
                ns.rf[d] = ns.rf[d] ^ ns.rf[s];
                ns.flags = set_sz(ns.flags, ns.rf[d]);
              end
            endcase
          end
        end
      end
      ST_ADDR: begin
        res.addr = rd_i;
        if (opc[8:6] == 3'd1) begin
          ns.step   = ST_WRITE;
          res.wr    = 1'b1;
          res.wdata = ns.rf[d];
        end else begin
          ns.step = ST_OPLO;
        end
      end
      ST_OPLO: begin
        if (st_i.dbl && mode != 3'd6) begin
          if (mode != 3'd0 && !mode[2]) begin
            mem  = 1'b1;
            mval = {rd_i[7:0], rd_i[7:0]};
            mcyc = 5'd8;
          end else begin
            ns.oplat = rd_i;
            ns.step  = ST_OPHI;
            if (mode == 3'd0) begin
              res.addr = st_i.addr + 16'd1;
            end else begin
              res.addr = ns.rf[mode];
              ns.rf[mode] = ns.rf[mode] + 16'd1;
            end
          end
        end else begin
          res.err = st_i.dbl && (mode == 3'd6);
          mem  = 1'b1;
          mval = rd_i;
          mcyc = 5'd6;
        end
      end
      ST_OPHI: begin
        mem  = 1'b1;
        mval = {rd_i[7:0], st_i.oplat[7:0]};
        mcyc = 5'd8;
      end
      ST_WRITE: begin
        fin  = 1'b1;
        fcyc = 5'd6;
      end
      ST_BDISP: begin
        disp = rd_i ^ (opc[5] ? 16'hFFFF : 16'h0000);
        fin  = 1'b1;
        if (!opc[4] && branch_taken(opc[3:0], st_i.flags)) begin
          ns.rf[7] = st_i.rf[7] + disp;
          fcyc = 5'd9;
        end else begin
          fcyc = 5'd7;
        end
      end
      ST_JMP1: begin
        ns.oplat = {6'd0, rd_i[9:0]};
        ns.step  = ST_JMP2;
        res.addr = st_i.rf[7];
        ns.rf[7] = st_i.rf[7] + 16'd1;
      end
      ST_JMP2: begin
        ta = {st_i.oplat[7:2], rd_i[9:0]};
        if (st_i.oplat[9:8] != 2'b11) ns.rf[{1'b1, st_i.oplat[9:8]}] = st_i.rf[7];
        ns.rf[7] = ta;
        if (st_i.oplat[1:0] == 2'b01) ns.ie = 1'b1;
        else if (st_i.oplat[1:0] == 2'b10) ns.ie = 1'b0;
        fin  = 1'b1;
        fcyc = 5'd12;
      end
      ST_IRQW: begin
        res.done   = 1'b1;
        res.cycles = 5'd7;
        ns.step    = ST_FETCH;
        res.addr   = st_i.rf[7];
      end
      default: begin
        ns.step  = ST_FETCH;
        res.addr = st_i.rf[7];
      end
    endcase

    // Memory-operand instructions complete here.
    if (mem) begin
      fin  = 1'b1;
      fcyc = mcyc;
      case (opc[8:6])
        3'd2: ns.rf[d] = mval;
        3'd3: begin
          ar = alu_add(ns.rf[d], mval, 1'b0, ns.flags);
          ns.rf[d] = ar.r;
          ns.flags = ar.f;
        end
        3'd4: begin
          ar = alu_add(ns.rf[d], ~mval, 1'b1, ns.flags);
          ns.rf[d] = ar.r;
          ns.flags = ar.f;
        end
        3'd5: begin
          ar = alu_add(ns.rf[d], ~mval, 1'b1, ns.flags);
          ns.flags = ar.f;
        end
        3'd6: begin
          ns.rf[d] = ns.rf[d] & mval;
          ns.flags = set_sz(ns.flags, ns.rf[d]);
        end
        default: begin
          ns.rf[d] = ns.rf[d] ^ mval;
          ns.flags = set_sz(ns.flags, ns.rf[d]);
        end
      endcase
    end

    // End of instruction: either push the PC for an interrupt or fetch.
    if (fin) begin
      res.done   = 1'b1;
      res.cycles = fcyc;
      ns.dbl     = 1'b0;
      res.wr     = 1'b0;
      res.wdata  = '0;
      if (ns.intr && ns.ie && irq_i) begin
        ns.step   = ST_IRQW;
        res.wr    = 1'b1;
        res.addr  = ns.rf[6];
        res.wdata = ns.rf[7];
        ns.rf[6]  = ns.rf[6] + 16'd1;
        ns.rf[7]  = ivec_i;
      end else begin
        ns.step  = ST_FETCH;
        res.addr = ns.rf[7];
      end
    end

    ns.addr = res.addr;
  end

  assign ns_o  = ns;
  assign res_o = res;

endmodule

// File: rtl/cp1600_cpu_core.sv
`timescale 1ns / 1ps
// CP1600 processor core driven one bus access at a time.
// Input stream: each word completes the pending bus access; tdata carries the
// read data (ignored after a write) and the interrupt and bus request levels.
// Output stream: one word per input word, naming the next bus access (address,
// direction, store data) and reporting when an instruction, an interrupt entry
// or a bus grant finished, with its machine cycle count.
// The next access is computed combinationally by the execute logic from the
// architectural state register and the input word, and lands in an output
// register: the output is valid in the cycle after input acceptance, and
// one word is accepted every cycle while the output side keeps taking words.
// The single output register sets that rate; when the receiver stalls, the
// output word holds and the input side stops accepting until it is taken.
// Reset loads R7 with 0x1000, the reset address register's default, and arms
// the opcode fetch at that address; a reset address write made before the
// first input word also moves that fetch. The APB port holds the reset
// address (offset 0) and the interrupt vector (offset 4).
`include "cp1600_cpu_core_macros.svh"
module cp1600_cpu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [15:0] read_data, [16] irq_request, [17] bus_request, [23:18] zero
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [15:0] next_address, [16] next_is_write, [32:17] write_data,
  // [33] instruction_done, [38:34] instruction_cycles, [39] bus_granted,
  // [40] stack_double_error, [47:41] zero
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import cp16_pkg::*;

  cpu_state_t  state_q, state_d;
  bus_res_t    res_q, res_d;
  logic        out_valid_q;
  logic [15:0] rst_addr_q;
  logic [15:0] ivec_q;
  logic        fresh_q;
  logic        in_acc;
  logic        cfg_wr;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign pready_o        = 1'b1;
  assign cfg_wr          = psel_i && penable_i && pwrite_i;

  cp16_exec u_exec (
    .st_i   (state_q),
    .rd_i   (s_axis_tdata_i[15:0]),
    .irq_i  (s_axis_tdata_i[16]),
    .breq_i (s_axis_tdata_i[17]),
    .ivec_i (ivec_q),
    .ns_o   (state_d),
    .res_o  (res_d)
  );

  // Architectural state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= '0;
      state_q.rf[7] <= ResetAddrDefault;
      state_q.addr  <= ResetAddrDefault;
      state_q.intr  <= 1'b1;
      state_q.step  <= ST_FETCH;
      rst_addr_q    <= ResetAddrDefault;
      ivec_q        <= IrqVectorDefault;
      fresh_q       <= 1'b1;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
        fresh_q <= 1'b0;
      end else if (cfg_wr && !paddr_i[2] && fresh_q) begin
        state_q.rf[7] <= pwdata_i[15:0];
        state_q.addr  <= pwdata_i[15:0];
      end
      if (cfg_wr) begin
        if (paddr_i[2]) ivec_q <= pwdata_i[15:0];
        else rst_addr_q <= pwdata_i[15:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q};
  assign prdata_o        = {16'd0, paddr_i[2] ? ivec_q : rst_addr_q};

  `CP16_ASSERT_NOW(a_grant_cost, out_valid_q && res_q.granted,
    res_q.done && (res_q.cycles == 5'd1), "bus grant must finish with one cycle")
  `CP16_ASSERT_NOW(a_write_step, out_valid_q,
    res_q.wr == (state_q.step == ST_WRITE || state_q.step == ST_IRQW),
    "write access out of step with the sequencer")
  `CP16_ASSERT_NOW(a_err_done, out_valid_q && res_q.err, res_q.done,
    "stack double-byte error outside an instruction end")
  `CP16_ASSERT_NEXT(a_fresh_clr, in_acc, !fresh_q, "reset address window still open")

endmodule
